// ===== rtl/core/gbtc_pkg.sv =====
// Shared constants, codes and types of the gap buffer text cursor unit.
package gbtc_pkg;

    localparam int CAPACITY = 4096;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int RUNE_W   = 21;
    localparam int FIELD_W  = 13;

    localparam logic [RUNE_W-1:0] NEWLINE = RUNE_W'(10);

    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MOVE_FWD   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // One write port and one read port into the rune store.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [RUNE_W-1:0] wdata;
        logic [PTR_W-1:0]  raddr;
    } store_req_t;

endpackage

// ===== rtl/core/gap_buffer_text_cursor_unit.sv =====
// Top level of the gap buffer text cursor unit: sequencer, counters and cursor tracking.
// An insert, a delete after the gap, a zero count or an unknown command goes from
// dispatch straight to the result state; busy falls after the result, and a new word
// is taken only while busy is low. A delete before or a move takes one step per rune,
// and a column recount after stepping back over a newline scans back to the start of
// the line. Results cannot be held off; reset clears the counters and the sequencer.
module gap_buffer_text_cursor_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [gbtc_pkg::CMD_W-1:0]         cmd,
    input  logic [gbtc_pkg::RUNE_W-1:0]        rune,
    input  logic [gbtc_pkg::FIELD_W-1:0]       count,
    output logic                               valid,
    output logic [gbtc_pkg::FIELD_W-1:0]       done_res,
    output logic [gbtc_pkg::FIELD_W-1:0]       text_length,
    output logic [gbtc_pkg::FIELD_W-1:0]       cursor_line,
    output logic [gbtc_pkg::FIELD_W-1:0]       cursor_col
);
    import gbtc_pkg::*;

    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    state_t state_reg, state_next;

    // The gap sits between before_reg runes at the bottom of the store and
    // after_reg runes at its top.
    logic [CNT_W-1:0]   before_reg, before_next;
    logic [CNT_W-1:0]   after_reg, after_next;
    logic [CNT_W-1:0]   line_reg, line_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [FIELD_W-1:0] done_reg, done_next;
    logic [CNT_W-1:0]   scan_pos_reg, scan_pos_next;
    logic               recount_reg, recount_next;

    // The accepted word, held for the length of the operation.
    logic [CMD_W-1:0]   cmd_reg;
    logic [RUNE_W-1:0]  rune_reg;
    logic [FIELD_W-1:0] count_reg;

    store_req_t        req;
    logic [RUNE_W-1:0] rd_data;

    logic               full;
    logic               is_newline;
    logic               back_nl;
    logic [FIELD_W-1:0] done_inc;
    logic               more;

    gbtc_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            before_reg   <= '0;
            after_reg    <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            done_reg     <= '0;
            scan_pos_reg <= '0;
            recount_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            before_reg   <= before_next;
            after_reg    <= after_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            done_reg     <= done_next;
            scan_pos_reg <= scan_pos_next;
            recount_reg  <= recount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg   <= cmd;
            rune_reg  <= rune;
            count_reg <= count;
        end
    end

    assign full       = (before_reg + after_reg) >= CAP_C;
    assign is_newline = (rd_data == NEWLINE);
    assign done_inc   = done_reg + FIELD_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        before_next   = before_reg;
        after_next    = after_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        done_next     = done_reg;
        scan_pos_next = scan_pos_reg;
        recount_next  = recount_reg;
        req           = '0;
        req.raddr     = PTR_W'(before_reg - ONE_C);
        req.wdata     = rd_data;
        back_nl       = 1'b0;
        more          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                done_next    = '0;
                recount_next = 1'b0;
                state_next   = ST_RESULT;
                unique case (cmd_reg) inside
                    CMD_INS_BEFORE:
                    begin
                        if (!full)
                        begin
                            req.we      = 1'b1;
                            req.waddr   = before_reg[PTR_W-1:0];
                            req.wdata   = rune_reg;
                            before_next = before_reg + ONE_C;
                            if (rune_reg == NEWLINE)
                            begin
                                line_next = line_reg + ONE_C;
                                col_next  = '0;
                            end
                            else
                            begin
                                col_next = col_reg + ONE_C;
                            end
                            done_next = FIELD_W'(1);
                        end
                    end
                    CMD_INS_AFTER:
                    begin
                        if (!full)
                        begin
                            req.we     = 1'b1;
                            req.waddr  = PTR_W'(CAP_C - ONE_C - after_reg);
                            req.wdata  = rune_reg;
                            after_next = after_reg + ONE_C;
                            done_next  = FIELD_W'(1);
                        end
                    end
                    CMD_DEL_BEFORE, CMD_MOVE_BACK:
                    begin
                        if ((count_reg != '0) && (before_reg != '0))
                        begin
                            req.raddr  = PTR_W'(before_reg - ONE_C);
                            state_next = ST_STEP;
                        end
                    end
                    CMD_MOVE_FWD:
                    begin
                        if ((count_reg != '0) && (after_reg != '0))
                        begin
                            req.raddr  = PTR_W'(CAP_C - after_reg);
                            state_next = ST_STEP;
                        end
                    end
                    CMD_DEL_AFTER:
                    begin
                        // Runes after the gap carry no line or column, so the
                        // whole delete is one subtraction.
                        if (int'(count_reg) >= int'(after_reg))
                        begin
                            done_next  = FIELD_W'(after_reg);
                            after_next = '0;
                        end
                        else
                        begin
                            done_next  = count_reg;
                            after_next = after_reg - CNT_W'(count_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_STEP:
            begin
                // rd_data holds the rune that this step carries across the gap;
                // the read for the following step is issued alongside.
                done_next = done_inc;
                unique case (cmd_reg) inside
                    CMD_DEL_BEFORE, CMD_MOVE_BACK:
                    begin
                        if (is_newline)
                        begin
                            back_nl = 1'b1;
                            if (line_reg != '0)
                            begin
                                line_next = line_reg - ONE_C;
                            end
                        end
                        else if (col_reg != '0)
                        begin
                            col_next = col_reg - ONE_C;
                        end
                        before_next = before_reg - ONE_C;
                        if (cmd_reg == CMD_MOVE_BACK)
                        begin
                            req.we     = 1'b1;
                            req.waddr  = PTR_W'(CAP_C - ONE_C - after_reg);
                            after_next = after_reg + ONE_C;
                        end
                        more      = (done_inc < count_reg) && (before_next != '0);
                        req.raddr = PTR_W'(before_reg - TWO_C);
                    end
                    CMD_MOVE_FWD:
                    begin
                        if (is_newline)
                        begin
                            line_next = line_reg + ONE_C;
                            col_next  = '0;
                        end
                        else
                        begin
                            col_next = col_reg + ONE_C;
                        end
                        req.we      = 1'b1;
                        req.waddr   = before_reg[PTR_W-1:0];
                        before_next = before_reg + ONE_C;
                        after_next  = after_reg - ONE_C;
                        more        = (done_inc < count_reg) && (after_next != '0);
                        req.raddr   = PTR_W'(CAP_C - after_reg + ONE_C);
                    end
                    default:
                    begin
                    end
                endcase

                recount_next = recount_reg || back_nl;
                if (!more)
                begin
                    if (recount_reg || back_nl)
                    begin
                        // The column is recounted once from where the gap
                        // finally rests, so it need not be exact during the steps.
                        state_next    = ST_SCAN;
                        scan_pos_next = before_next;
                        col_next      = '0;
                        req.raddr     = PTR_W'(before_next - ONE_C);
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the rune just below scan_pos_reg.
                if ((scan_pos_reg == '0) || is_newline)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    col_next      = col_reg + ONE_C;
                    scan_pos_next = scan_pos_reg - ONE_C;
                    req.raddr     = PTR_W'(scan_pos_reg - TWO_C);
                end
            end

            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = (state_reg == ST_RESULT);
    assign done_res    = done_reg;
    assign text_length = FIELD_W'(before_reg + after_reg);
    assign cursor_line = FIELD_W'(line_reg);
    assign cursor_col  = FIELD_W'(col_reg);

`ifndef ASSERT_OFF
    // The text never outgrows the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (before_reg + after_reg) <= CAP_C)
        else $error("text longer than the store");

    // A result strobe lasts one cycle and is followed by readiness.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid && !busy)
        else $error("result strobe held or not followed by idle");

    // No more steps are reported than were asked for.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (cmd_reg != CMD_INS_BEFORE) && (cmd_reg != CMD_INS_AFTER)
        |-> done_res <= count_reg)
        else $error("more steps done than requested");

    // Every newline counted, and the column, lie within the text before the gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg <= before_reg) && (col_reg <= before_reg))
        else $error("cursor line or column beyond the text before the gap");

    // A taken word makes the block busy until its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !valid)
        else $error("word taken without the block going busy");
`endif

endmodule

// ===== rtl/core/gbtc_store.sv =====
// Rune store of the gap buffer: one write and one registered read per cycle.
module gbtc_store (
    input  logic                            clk,
    input  gbtc_pkg::store_req_t            req,
    output logic [gbtc_pkg::RUNE_W-1:0]     rd_data
);
    import gbtc_pkg::*;

    logic [RUNE_W-1:0] rune_mem [CAPACITY];
    logic [RUNE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rune_mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= rune_mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/gap_buffer_text_cursor_unit_test.sv =====
// Self-checking testbench for the gap buffer text cursor unit.
`timescale 1ns / 1ps

module gap_buffer_text_cursor_unit_test;

    import gbtc_pkg::*;

    // The block has no names for the two spare command codes, so the bench keeps its own.
    localparam logic [CMD_W-1:0] CMD_RESERVED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED_B = 3'd7;

    localparam logic [RUNE_W-1:0] RUNE_TOP = RUNE_W'(21'h10FFFF);
    localparam int RANDOM_WORDS   = 1380;
    localparam int QUIET_TAIL     = 150;
    localparam int TEXT_SOFT_MAX  = 400;
    localparam int DIRECTED_ROWS  = 19;
    // The slowest correct word walks 4096 steps and then rescans at most one line of 4096 runes.
    localparam int STALL_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 40;

    // One result word as the block reports it.
    typedef struct packed {
        logic [FIELD_W-1:0] steps;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] col;
    } report_t;

    // One row of the directed table: the word to send and, where it is obvious,
    // the report that must come back.
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [RUNE_W-1:0]  ch;
        logic [FIELD_W-1:0] reps;
        bit                 typed;
        report_t            want;
    } table_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   cmd;
    logic [RUNE_W-1:0]  rune;
    logic [FIELD_W-1:0] count;
    logic               valid;
    logic [FIELD_W-1:0] done_res;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] cursor_line;
    logic [FIELD_W-1:0] cursor_col;

    // Shadow copy of the text: runes before the gap at the bottom, runes after
    // the gap at the top, exactly as the block lays them out.
    logic [RUNE_W-1:0] shadow_text [CAPACITY];
    int                runes_before;
    int                runes_after;
    int                line_no;
    int                col_no;

    report_t           expected_reports [$];
    table_row_t        directed_table [DIRECTED_ROWS];

    // A typed expectation travels with the word it belongs to.
    bit                want_typed;
    report_t           typed_report;

    int                mismatches;
    int                words_sent;
    int                reports_checked;
    int                inserts_refused;
    int                stall_cycles;

    gap_buffer_text_cursor_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .rune        (rune),
        .count       (count),
        .valid       (valid),
        .done_res    (done_res),
        .text_length (text_length),
        .cursor_line (cursor_line),
        .cursor_col  (cursor_col)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic report_t make_report(int s, int n, int l, int c);
        report_t r;
        r.steps  = FIELD_W'(s);
        r.length = FIELD_W'(n);
        r.line   = FIELD_W'(l);
        r.col    = FIELD_W'(c);
        return r;
    endfunction

    // Counts the runes that sit between the newline before index pos and pos itself.
    function automatic int column_before(int pos);
        int c;
        c = 0;
        while (pos > 0 && shadow_text[pos-1] != NEWLINE)
        begin
            c++;
            pos--;
        end
        return c;
    endfunction

    // Updates line and column for the rune just before the gap leaving the front part.
    // Stepping back over a newline costs a line and forces the column to be recounted
    // from the newline before it, not merely decremented.
    function automatic void retreat_cursor();
        if (shadow_text[runes_before-1] == NEWLINE)
        begin
            if (line_no > 0)
                line_no--;
            col_no = column_before(runes_before - 1);
        end
        else if (col_no > 0)
        begin
            col_no--;
        end
    endfunction

    // Applies one edit word to the shadow text and returns the report it should give.
    function automatic report_t apply_edit(logic [CMD_W-1:0] op, logic [RUNE_W-1:0] ch,
                                           logic [FIELD_W-1:0] reps);
        int                steps;
        bit                full;
        logic [RUNE_W-1:0] moved;
        steps = 0;
        full  = (runes_before + runes_after) >= CAPACITY;
        case (op)
            CMD_INS_BEFORE:
            begin
                if (!full)
                begin
                    shadow_text[runes_before] = ch;
                    runes_before++;
                    if (ch == NEWLINE)
                    begin
                        line_no++;
                        col_no = 0;
                    end
                    else
                    begin
                        col_no++;
                    end
                    steps = 1;
                end
            end
            CMD_INS_AFTER:
            begin
                if (!full)
                begin
                    shadow_text[CAPACITY-1-runes_after] = ch;
                    runes_after++;
                    steps = 1;
                end
            end
            CMD_DEL_BEFORE:
            begin
                while (steps < reps && runes_before > 0)
                begin
                    retreat_cursor();
                    runes_before--;
                    steps++;
                end
            end
            CMD_DEL_AFTER:
            begin
                while (steps < reps && runes_after > 0)
                begin
                    runes_after--;
                    steps++;
                end
            end
            CMD_MOVE_BACK:
            begin
                while (steps < reps && runes_before > 0)
                begin
                    retreat_cursor();
                    shadow_text[CAPACITY-1-runes_after] = shadow_text[runes_before-1];
                    runes_before--;
                    runes_after++;
                    steps++;
                end
            end
            CMD_MOVE_FWD:
            begin
                while (steps < reps && runes_after > 0)
                begin
                    moved = shadow_text[CAPACITY-runes_after];
                    if (moved == NEWLINE)
                    begin
                        line_no++;
                        col_no = 0;
                    end
                    else
                    begin
                        col_no++;
                    end
                    shadow_text[runes_before] = moved;
                    runes_before++;
                    runes_after--;
                    steps++;
                end
            end
            default:
            begin
            end
        endcase
        if ((op == CMD_INS_BEFORE || op == CMD_INS_AFTER) && steps == 0)
            inserts_refused++;
        return make_report(steps, runes_before + runes_after, line_no, col_no);
    endfunction

    // A rune mix that favours newlines so that line and column tracking is busy,
    // while still reaching both ends of the code point range.
    function automatic logic [RUNE_W-1:0] pick_rune();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return NEWLINE;
        else if (roll < 30)
            return '0;
        else if (roll < 33)
            return RUNE_TOP;
        else if (roll < 60)
            return RUNE_W'($urandom_range(32, 126));
        else
            return RUNE_W'($urandom_range(0, 1114111));
    endfunction

    // Mostly short repeats, with zero and the full 4096 now and then.
    function automatic logic [FIELD_W-1:0] pick_repeats();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 8)
            return FIELD_W'(4096);
        else if (roll < 12)
            return FIELD_W'($urandom_range(0, 4096));
        else if (roll < 24)
            return FIELD_W'($urandom_range(0, 64));
        else
            return FIELD_W'($urandom_range(1, 6));
    endfunction

    // Called at a falling edge: presents a word and holds it until the block takes it.
    // Start is left high afterwards, so back-to-back words never drop it.
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [RUNE_W-1:0] ch,
                             input logic [FIELD_W-1:0] reps, input bit typed,
                             input report_t want);
        start        = 1'b1;
        cmd          = op;
        rune         = ch;
        count        = reps;
        want_typed   = typed;
        typed_report = want;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Lowers start for a burst of idle cycles, beginning at the next falling edge.
    task automatic hold_off(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Picks one random word from the current state of the text and sends it. The choice
    // is made at a falling edge, so the shadow text is settled when it is read.
    task automatic send_random_word();
        logic [CMD_W-1:0] op;
        int               roll;
        @(negedge clk);
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = ($urandom_range(0, 1) != 0) ? CMD_RESERVED_A : CMD_RESERVED_B;
        else if (roll < 30)
            op = CMD_INS_BEFORE;
        else if (roll < 42)
            op = CMD_INS_AFTER;
        else if (roll < 54)
            op = CMD_DEL_BEFORE;
        else if (roll < 62)
            op = CMD_DEL_AFTER;
        else if (roll < 81)
            op = CMD_MOVE_BACK;
        else
            op = CMD_MOVE_FWD;
        // Long texts only make steps slower, so inserts turn into deletes past a soft ceiling.
        if ((op == CMD_INS_BEFORE || op == CMD_INS_AFTER)
            && runes_before + runes_after > TEXT_SOFT_MAX)
            op = (runes_before > runes_after) ? CMD_DEL_BEFORE : CMD_DEL_AFTER;
        send_word(op, pick_rune(), pick_repeats(), 1'b0, '0);
    endtask

    // Scoreboard: checks each report against the oldest expectation, predicts the
    // report of every word that is taken, and watches for the block stalling.
    always @(posedge clk)
    begin
        report_t want;
        report_t made;
        if (rst_n)
        begin
            // The check comes first, so a report and a new word on the same edge never mix.
            if (valid)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report arrived with no word outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    reports_checked++;
                    if (done_res !== want.steps)
                    begin
                        $error("done_res: expected %0d, got %0d", want.steps, done_res);
                        mismatches++;
                    end
                    if (text_length !== want.length)
                    begin
                        $error("text_length: expected %0d, got %0d", want.length, text_length);
                        mismatches++;
                    end
                    if (cursor_line !== want.line)
                    begin
                        $error("cursor_line: expected %0d, got %0d", want.line, cursor_line);
                        mismatches++;
                    end
                    if (cursor_col !== want.col)
                    begin
                        $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                // The shadow text moves on for every word, even where the table
                // supplies the expected report by hand.
                made = apply_edit(cmd, rune, count);
                expected_reports.push_back(want_typed ? typed_report : made);
            end
            if ((start && !busy) || valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", stall_cycles);
                $display("gap_buffer_text_cursor_unit test failed");
                $finish;
            end
        end
    end

    initial
    begin
        bit quiet;
        mismatches      = 0;
        words_sent      = 0;
        reports_checked = 0;
        inserts_refused = 0;
        stall_cycles    = 0;
        runes_before    = 0;
        runes_after     = 0;
        line_no         = 0;
        col_no          = 0;
        want_typed      = 1'b0;
        typed_report    = '0;
        start           = 1'b0;
        cmd             = CMD_INS_BEFORE;
        rune            = '0;
        count           = '0;
        rst_n           = 1'b0;

        // The opening rows work on an empty text, so their reports are plain zeros.
        // The short text built next is "a", newline, top rune, zero before the gap,
        // and "b" and a newline after it, which makes the hand-typed columns easy to
        // follow. The rest of the table steps back across the newline, runs off both
        // ends of the text and finally empties it again.
        directed_table = '{
            '{CMD_MOVE_BACK,  RUNE_W'(0),    FIELD_W'(5),    1'b1, make_report(0, 0, 0, 0)},
            '{CMD_RESERVED_A, RUNE_W'(0),    FIELD_W'(3),    1'b1, make_report(0, 0, 0, 0)},
            '{CMD_DEL_AFTER,  RUNE_W'(0),    FIELD_W'(4096), 1'b1, make_report(0, 0, 0, 0)},
            '{CMD_INS_BEFORE, RUNE_W'('h61), FIELD_W'(0),    1'b1, make_report(1, 1, 0, 1)},
            '{CMD_INS_BEFORE, NEWLINE,       FIELD_W'(4096), 1'b1, make_report(1, 2, 1, 0)},
            '{CMD_INS_BEFORE, RUNE_TOP,      FIELD_W'(0),    1'b1, make_report(1, 3, 1, 1)},
            '{CMD_INS_BEFORE, RUNE_W'(0),    FIELD_W'(0),    1'b1, make_report(1, 4, 1, 2)},
            '{CMD_INS_AFTER,  NEWLINE,       FIELD_W'(0),    1'b1, make_report(1, 5, 1, 2)},
            '{CMD_INS_AFTER,  RUNE_W'('h62), FIELD_W'(0),    1'b1, make_report(1, 6, 1, 2)},
            '{CMD_MOVE_BACK,  RUNE_W'(0),    FIELD_W'(0),    1'b1, make_report(0, 6, 1, 2)},
            '{CMD_MOVE_BACK,  RUNE_TOP,      FIELD_W'(3),    1'b0, '0},
            '{CMD_MOVE_FWD,   RUNE_W'(0),    FIELD_W'(4096), 1'b0, '0},
            '{CMD_DEL_BEFORE, RUNE_W'(0),    FIELD_W'(2),    1'b0, '0},
            '{CMD_RESERVED_B, RUNE_W'('h61), FIELD_W'(1),    1'b0, '0},
            '{CMD_MOVE_BACK,  RUNE_W'(0),    FIELD_W'(4096), 1'b0, '0},
            '{CMD_DEL_AFTER,  RUNE_W'(0),    FIELD_W'(1),    1'b0, '0},
            '{CMD_INS_BEFORE, NEWLINE,       FIELD_W'(0),    1'b0, '0},
            '{CMD_DEL_BEFORE, RUNE_W'(0),    FIELD_W'(4096), 1'b0, '0},
            '{CMD_DEL_AFTER,  RUNE_W'(0),    FIELD_W'(4096), 1'b0, '0}
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            @(negedge clk);
            send_word(directed_table[i].op, directed_table[i].ch, directed_table[i].reps,
                      directed_table[i].typed, directed_table[i].want);
            if ($urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 16));
        end

        // Random part. Idling comes in stretches: every 64 words a new choice is made
        // between a stretch without idle bursts and one with frequent bursts. The tail runs flat out.
        quiet = 1'b0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 64 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            send_random_word();
            if (!quiet && i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 99) < 40)
                hold_off($urandom_range(1, 16));
        end

        @(negedge clk);
        start = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        // Every word has one report, so a short settle only catches stray strobes.
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d edit words and checked %0d reports, %0d of them refused inserts.",
                 words_sent, reports_checked, inserts_refused);
        $display("Moves and deletes ran off both ends of the text; %0d mismatches were seen.",
                 mismatches);
        if (mismatches == 0)
            $display("gap_buffer_text_cursor_unit test passed");
        else
            $display("gap_buffer_text_cursor_unit test failed");
        $finish;
    end

endmodule
